// ----- rtl/core/lpht_pkg.sv -----
// Shared types, codes and helpers for the linear probing hash table.
// Holds the request and response word layouts, status and slot mark codes
// and the character code mapping. No dependencies.
package lpht_pkg;

	// Defaults for the top level parameters
	localparam int MAX_SLOTS_DEF = 64;
	localparam int HASH_MOD_DEF  = 65407;

	// Key layout and hashing
	localparam int KEY_CHARS    = 8;
	localparam int CHAR_W       = 8;
	localparam int KEY_W        = 64;
	localparam int VALUE_W      = 48;
	localparam int CODE_RADIX   = 62;
	localparam int LETTER_COUNT = 26;
	localparam int CODE_W       = 6;

	// Configuration register
	localparam int        TSIZE_W     = 7;
	localparam int        TSIZE_RESET = 64;
	localparam int        PADDR_W     = 3;
	localparam int        PDATA_W     = 32;
	localparam logic      REG_TSIZE   = 1'b0;

	// Result word
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 6;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	// Request kinds
	localparam logic REQ_PUT    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Slot marks
	localparam int                MARK_W     = 2;
	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	// ASCII bounds
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;

	typedef struct packed {
		logic               req_type;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} rsp_t;

	// Map one ASCII character to its hash code; anything unlisted maps to zero
	function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] ch);
		logic [CODE_W-1:0] code;
		code = '0;
		if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			code = CODE_W'(ch - CH_LOWER_A);
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			code = CODE_W'(ch - CH_UPPER_A) + CODE_W'(LETTER_COUNT);
		end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			code = CODE_W'(ch - CH_DIGIT_0) + CODE_W'(2 * LETTER_COUNT);
		end
		return code;
	endfunction

endpackage

// ----- rtl/core/linear_probe_hash_table.sv -----
// Key-value table with open addressing, linear probing and tombstones.
// After reset the block sweeps its slot mark memory clear, one slot a cycle, over all MAX_SLOTS
// slots, and holds req_stall high meanwhile (slot count writes are taken as ever). Each
// request then runs an accept state, per key character a multiply by 62, a reciprocal
// estimate and a correcting subtract, a step to close the hash, a restoring division for
// the home slot, per slot probed a registered memory read and then a compare, and a final
// state that writes back and posts the response word once the output register is free.
// One request is in flight at a time; a finished response waits in an output register
// while the next request is taken.
// Depends on lpht_pkg.
module linear_probe_hash_table
	import lpht_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int HASH_MOD  = HASH_MOD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// Derived widths
	localparam int IW  = $clog2(MAX_SLOTS);
	localparam int SW  = $clog2(MAX_SLOTS + 1);
	localparam int HW  = $clog2(HASH_MOD);
	localparam int XW  = $clog2(CODE_RADIX * HASH_MOD);
	localparam int QW  = $clog2(CODE_RADIX);
	localparam int UW  = ((HW > SW) ? HW : SW) + 1;
	localparam int DW  = $clog2(HW + 1);
	localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / HASH_MOD);

	// Sequencer states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_HMUL  = 4'd2;
	localparam logic [3:0] S_HEST  = 4'd3;
	localparam logic [3:0] S_HRED  = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_READ  = 4'd6;
	localparam logic [3:0] S_CHECK = 4'd7;
	localparam logic [3:0] S_FINAL = 4'd8;

	logic [3:0]          state_q;
	logic [TSIZE_W-1:0]  tsize_q;
	logic [IW-1:0]       clr_q;

	// Request context
	logic                req_type_q;
	logic [KEY_W-1:0]    nkey_q;
	logic [KEY_W-1:0]    hk_q;
	logic [VALUE_W-1:0]  value_q;

	// Hash and division datapath
	logic [HW-1:0]       h_q;
	logic [XW-1:0]       x_q;
	logic [QW-1:0]       qe_q;
	logic [SW-1:0]       rem_q;
	logic [HW-1:0]       hs_q;
	logic [DW-1:0]       dcnt_q;

	// Probe state
	logic [IW-1:0]       idx_q;
	logic [SW-1:0]       step_q;
	logic                have_free_q;
	logic [IW-1:0]       free_q;
	logic [IW-1:0]       act_q;
	logic [STATUS_W-1:0] status_q;

	// Slot memories
	logic [MARK_W-1:0]   mark_mem [MAX_SLOTS];
	logic [KEY_W-1:0]    key_mem  [MAX_SLOTS];
	logic [VALUE_W-1:0]  val_mem  [MAX_SLOTS];
	logic [MARK_W-1:0]   mark_rd_q;
	logic [KEY_W-1:0]    key_rd_q;

	// Output register
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                cfg_write;
	logic                out_free;
	logic [SW-1:0]       size;
	logic [KEY_W-1:0]    nkey;
	logic [CHAR_W-1:0]   top_char;
	logic [XW-1:0]       x_next;
	logic [2*XW-1:0]     est_prod;
	logic [XW-1:0]       r_raw;
	logic [SW:0]         div_t;

	// Shared subtract and compare unit
	logic [UW-1:0]       sub_a;
	logic [UW-1:0]       sub_b;
	logic [UW:0]         sub_diff;
	logic                sub_ge;
	logic                sub_eq;

	// Probe decision
	logic                is_empty;
	logic                is_match;
	logic                take_free;
	logic                have_now;
	logic [IW-1:0]       free_now;
	logic                probe_end;
	logic [IW-1:0]       idx_next;
	logic [STATUS_W-1:0] end_status;
	logic [IW-1:0]       end_slot;

	// Memory write port
	logic                mark_we;
	logic [MARK_W-1:0]   mark_wd;
	logic                kv_key_we;
	logic                kv_val_we;
	logic [IW-1:0]       wr_addr;

	// Handshakes
	assign accept    = (state_q == S_IDLE) && req_valid;
	assign req_stall = (state_q != S_IDLE);
	assign cfg_write = psel && penable && pwrite && pready;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[PADDR_W-1] == REG_TSIZE) ?
		PDATA_W'(tsize_q) : '0;

	// Clamp table size into 1..MAX_SLOTS
	always_comb begin
		if (tsize_q == '0) begin
			size = SW'(1);
		end else if (int'(tsize_q) > MAX_SLOTS) begin
			size = SW'(MAX_SLOTS);
		end else begin
			size = SW'(tsize_q);
		end
	end

	// Keep key characters up to the first zero byte, at most KEY_CHARS
	always_comb begin
		logic              alive;
		logic [CHAR_W-1:0] b;
		alive = 1'b1;
		nkey  = '0;
		for (int i = 0; i < KEY_W / CHAR_W; i++) begin
			b     = req.key[KEY_W-1-CHAR_W*i -: CHAR_W];
			alive = alive && (b != '0) && (i < KEY_CHARS);
			if (alive) begin
				nkey[KEY_W-1-CHAR_W*i -: CHAR_W] = b;
			end
		end
	end

	// Hash datapath: h*62 + code, then reciprocal quotient estimate, then remainder
	assign top_char = hk_q[KEY_W-1 -: CHAR_W];
	assign x_next   = XW'(h_q) * XW'(CODE_RADIX) + XW'(char_code(top_char));
	assign est_prod = (2*XW)'(x_q) * (2*XW)'(RECIP);
	assign r_raw    = x_q - XW'(qe_q) * XW'(HASH_MOD);
	assign div_t    = {rem_q, hs_q[HW-1]};

	// Select operands for the shared unit
	always_comb begin
		case (state_q)
			S_HRED: begin
				sub_a = UW'(r_raw);
				sub_b = UW'(HASH_MOD);
			end
			S_DIV: begin
				sub_a = UW'(div_t);
				sub_b = UW'(size);
			end
			S_CHECK: begin
				sub_a = UW'(step_q) + UW'(1);
				sub_b = UW'(size);
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_diff[UW];
	assign sub_eq   = (sub_diff == '0);

	// Evaluate one probed slot
	assign is_empty  = (mark_rd_q == MARK_EMPTY);
	assign is_match  = (mark_rd_q == MARK_USED) && (key_rd_q == nkey_q);
	assign take_free = !have_free_q && (mark_rd_q != MARK_USED);
	assign have_now  = have_free_q || take_free;
	assign free_now  = have_free_q ? free_q : idx_q;
	assign probe_end = is_empty || is_match || sub_eq;
	assign idx_next  = ((SW+1)'(idx_q) + (SW+1)'(1) == (SW+1)'(size)) ?
		'0 : idx_q + IW'(1);

	always_comb begin
		end_status = ST_NOTFOUND;
		end_slot   = '0;
		if (req_type_q == REQ_REMOVE) begin
			if (is_match) begin
				end_status = ST_REMOVED;
				end_slot   = idx_q;
			end
		end else if (is_match) begin
			end_status = ST_UPDATED;
			end_slot   = idx_q;
		end else if (have_now) begin
			end_status = ST_INSERTED;
			end_slot   = free_now;
		end else begin
			end_status = ST_FULL;
		end
	end

	// Drive the single write port: clearing sweep or write-back
	always_comb begin
		mark_we   = 1'b0;
		mark_wd   = MARK_EMPTY;
		kv_key_we = 1'b0;
		kv_val_we = 1'b0;
		wr_addr   = act_q;
		if (state_q == S_CLEAR) begin
			mark_we = 1'b1;
			wr_addr = clr_q;
		end else if (state_q == S_FINAL && out_free) begin
			case (status_q)
				ST_REMOVED: begin
					mark_we = 1'b1;
					mark_wd = MARK_TOMB;
				end
				ST_UPDATED: begin
					kv_val_we = 1'b1;
				end
				ST_INSERTED: begin
					mark_we   = 1'b1;
					mark_wd   = MARK_USED;
					kv_key_we = 1'b1;
					kv_val_we = 1'b1;
				end
				default: begin
					mark_we = 1'b0;
				end
			endcase
		end
	end

	// Slot memories: registered read at the probe index, one write port
	always_ff @(posedge clk) begin
		mark_rd_q <= mark_mem[idx_q];
		key_rd_q  <= key_mem[idx_q];
		if (mark_we) begin
			mark_mem[wr_addr] <= mark_wd;
		end
		if (kv_key_we) begin
			key_mem[wr_addr] <= nkey_q;
		end
		if (kv_val_we) begin
			val_mem[wr_addr] <= value_q;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= TSIZE_W'(TSIZE_RESET);
		end else if (cfg_write && paddr[PADDR_W-1] == REG_TSIZE) begin
			tsize_q <= pwdata[TSIZE_W-1:0];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			have_free_q <= 1'b0;
		end else begin
			// drop a taken response word
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(MAX_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HMUL;
					end
				end
				S_HMUL: begin
					if (top_char == '0) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_HEST;
					end
				end
				S_HEST: begin
					state_q <= S_HRED;
				end
				S_HRED: begin
					state_q <= S_HMUL;
				end
				S_DIV: begin
					if (dcnt_q == DW'(1)) begin
						have_free_q <= 1'b0;
						state_q     <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (probe_end) begin
						state_q <= S_FINAL;
					end else begin
						have_free_q <= have_now;
						state_q     <= S_READ;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_type_q <= req.req_type;
					nkey_q     <= nkey;
					hk_q       <= nkey;
					value_q    <= req.value;
					h_q        <= '0;
				end
			end
			S_HMUL: begin
				// advance one character, or start the home slot division
				x_q    <= x_next;
				hk_q   <= hk_q << CHAR_W;
				rem_q  <= '0;
				hs_q   <= h_q;
				dcnt_q <= DW'(HW);
			end
			S_HEST: begin
				qe_q <= QW'(est_prod >> XW);
			end
			S_HRED: begin
				h_q <= HW'(sub_ge ? sub_diff[UW-1:0] : sub_a);
			end
			S_DIV: begin
				rem_q  <= SW'(sub_ge ? sub_diff[UW-1:0] : sub_a);
				hs_q   <= hs_q << 1;
				dcnt_q <= dcnt_q - DW'(1);
				idx_q  <= IW'(sub_ge ? sub_diff[UW-1:0] : sub_a);
				step_q <= '0;
			end
			S_CHECK: begin
				if (probe_end) begin
					status_q <= end_status;
					act_q    <= end_slot;
				end else begin
					free_q <= free_now;
					idx_q  <= idx_next;
					step_q <= step_q + SW'(1);
				end
			end
			S_FINAL: begin
				if (out_free) begin
					rsp_q.status <= status_q;
					rsp_q.slot   <= SLOT_W'(act_q);
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

endmodule

// ----- dv/linear_probe_hash_table_tb.sv -----
// Self-checking bench for the linear probing hash table: sends put and remove words,
// programs the slot count over the APB port and checks every response word in order.
// Depends on lpht_pkg and linear_probe_hash_table.
module linear_probe_hash_table_tb
	import lpht_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF        = 5;
	localparam int SLOTS           = MAX_SLOTS_DEF;
	localparam int QUIET_LIMIT     = 5000;
	localparam int SETTLE_CYCLES   = 200;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int PHASE_COUNT     = 9;
	localparam int PHASE_ITEMS     = 42;
	localparam int POOL_DEPTH      = 32;
	localparam int MAX_REPORTS     = 10;

	localparam logic [PADDR_W-1:0] TSIZE_ADDR = PADDR_W'(4 * int'(REG_TSIZE));
	localparam logic [PDATA_W-1:0] PHASE_SIZES [PHASE_COUNT] = '{
		32'd64, 32'hABCD_0005, 32'd1, 32'd16, 32'd0, 32'd127, 32'd3, 32'd40, 32'd64
	};

	// Shadow of the slot store; predicts the response word of every accepted request
	class hash_table_scoreboard;
		logic [MARK_W-1:0]  marks  [SLOTS];
		logic [KEY_W-1:0]   keys   [SLOTS];
		logic [VALUE_W-1:0] values [SLOTS];
		logic [TSIZE_W-1:0] size_reg;
		rsp_t               expected_outcomes [$];
		int                 mismatches;
		int                 checked;
		int                 status_seen [5];

		function new();
			foreach (marks[i]) marks[i] = MARK_EMPTY;
			foreach (status_seen[i]) status_seen[i] = 0;
			size_reg   = TSIZE_W'(TSIZE_RESET);
			mismatches = 0;
			checked    = 0;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("[%0t] mismatch: %s", $time, msg);
			end
		endfunction

		function void set_size(logic [TSIZE_W-1:0] v);
			size_reg = v;
		endfunction

		function int pending();
			return expected_outcomes.size();
		endfunction

		// Map one character to its base-62 digit; unlisted bytes count as zero
		function int unsigned digit_of(logic [7:0] b);
			if (b >= CH_LOWER_A && b <= CH_LOWER_Z) return b - CH_LOWER_A;
			if (b >= CH_UPPER_A && b <= CH_UPPER_Z) return LETTER_COUNT + (b - CH_UPPER_A);
			if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) return 2 * LETTER_COUNT + (b - CH_DIGIT_0);
			return 0;
		endfunction

		// Drop every byte from the first zero byte on
		function logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] k);
			logic [KEY_W-1:0] t;
			logic [7:0]       b;
			t = '0;
			for (int i = 0; i < KEY_CHARS; i++) begin
				b = k[KEY_W-1-8*i -: 8];
				if (b == 8'h00) break;
				t[KEY_W-1-8*i -: 8] = b;
			end
			return t;
		endfunction

		function int unsigned name_hash(logic [KEY_W-1:0] nk);
			int unsigned h;
			logic [7:0]  b;
			h = 0;
			for (int i = 0; i < KEY_CHARS; i++) begin
				b = nk[KEY_W-1-8*i -: 8];
				if (b == 8'h00) break;
				h = (h * CODE_RADIX + digit_of(b)) % HASH_MOD_DEF;
			end
			return h;
		endfunction

		// Walk the probe chain, apply the request to the shadow store, return the outcome
		function rsp_t probe_outcome(req_t r);
			int unsigned      span;
			int unsigned      idx;
			int unsigned      free_idx;
			bit               have_free;
			bit               found;
			logic [KEY_W-1:0] nk;
			rsp_t             o;
			span = (size_reg == 0) ? 1 : (size_reg > SLOTS) ? SLOTS : size_reg;
			nk = trim_key(r.key);
			idx = name_hash(nk) % span;
			have_free = 1'b0;
			found = 1'b0;
			free_idx = 0;
			for (int unsigned step = 0; step < span; step++) begin
				if (marks[idx] == MARK_EMPTY) begin
					if (!have_free) begin
						have_free = 1'b1;
						free_idx = idx;
					end
					break;
				end
				if (marks[idx] == MARK_USED && keys[idx] == nk) begin
					found = 1'b1;
					break;
				end
				if (marks[idx] != MARK_USED && !have_free) begin
					have_free = 1'b1;
					free_idx = idx;
				end
				idx = (idx + 1 == span) ? 0 : idx + 1;
			end
			o.status = ST_NOTFOUND;
			o.slot = '0;
			if (r.req_type == REQ_REMOVE) begin
				if (found) begin
					marks[idx] = MARK_TOMB;
					o.status = ST_REMOVED;
					o.slot = SLOT_W'(idx);
				end
			end else if (found) begin
				values[idx] = r.value;
				o.status = ST_UPDATED;
				o.slot = SLOT_W'(idx);
			end else if (have_free) begin
				marks[free_idx] = MARK_USED;
				keys[free_idx] = nk;
				values[free_idx] = r.value;
				o.status = ST_INSERTED;
				o.slot = SLOT_W'(free_idx);
			end else begin
				o.status = ST_FULL;
			end
			return o;
		endfunction

		function void note_request(req_t r);
			expected_outcomes.push_back(probe_outcome(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_outcomes.size() == 0) begin
				flag($sformatf("status %0d slot %0d arrived with nothing expected",
					got.status, got.slot));
				return;
			end
			want = expected_outcomes.pop_front();
			checked++;
			if (want.status <= ST_NOTFOUND) status_seen[want.status]++;
			if (got.status !== want.status) begin
				flag($sformatf("response %0d status expected %0d actual %0d",
					checked, want.status, got.status));
			end
			if (got.slot !== want.slot) begin
				flag($sformatf("response %0d slot expected %0d actual %0d",
					checked, want.slot, got.slot));
			end
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	hash_table_scoreboard table_sb;
	logic [KEY_W-1:0]     name_pool [POOL_DEPTH];
	int                   sender_idle_pct    = 0;
	int                   receiver_stall_pct = 0;
	int                   hold_request       = 0;
	int                   quiet_cycles       = 0;
	int                   requests_sent      = 0;
	int                   sizes_visited      = 0;

	linear_probe_hash_table u_dut (.*);

	always #CLK_HALF clk = ~clk;

	// Response side: check each accepted word, then pick the stall for the next cycle
	initial begin : response_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) table_sb.check_response(rsp);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Stop the run once nothing has moved on any port for too long
	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no progress for %0d cycles, %0d responses outstanding",
			QUIET_LIMIT, table_sb.pending());
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [7:0] random_char();
		case ($urandom_range(4))
			1: return CH_UPPER_A + 8'($urandom_range(25));
			2: return CH_DIGIT_0 + 8'($urandom_range(9));
			3: return 8'($urandom_range(255, 1));
			default: return CH_LOWER_A + 8'($urandom_range(25));
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] random_name(int len);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < len; i++) k[KEY_W-1-8*i -: 8] = random_char();
		return k;
	endfunction

	// Fill the bytes behind the terminating zero with noise; the key stays the same
	function automatic logic [KEY_W-1:0] junk_tail(logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] t;
		bit               ended;
		t = k;
		ended = 1'b0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			if (ended) t[KEY_W-1-8*i -: 8] = 8'($urandom);
			else if (t[KEY_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
		end
		return t;
	endfunction

	function automatic logic [KEY_W-1:0] text_key(string s);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < s.len() && i < KEY_CHARS; i++) k[KEY_W-1-8*i -: 8] = s[i];
		return k;
	endfunction

	function automatic req_t make_req(logic kind, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
		req_t w;
		w.req_type = kind;
		w.key = k;
		w.value = v;
		return w;
	endfunction

	// Mostly pooled names so updates and removes hit; some fresh and raw keys
	function automatic req_t random_request();
		req_t w;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 70) w.key = name_pool[$urandom_range(POOL_DEPTH - 1)];
		else if (pick < 88) w.key = random_name($urandom_range(KEY_CHARS));
		else w.key = {$urandom, $urandom};
		if ($urandom_range(99) < 25) w.key = junk_tail(w.key);
		w.req_type = ($urandom_range(99) < 35) ? REQ_REMOVE : REQ_PUT;
		w.value = VALUE_W'({$urandom, $urandom});
		return w;
	endfunction

	// Offer one request word, idling first at random; hold it until taken
	task automatic send_request(req_t w);
		if ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		table_sb.note_request(w);
		requests_sent++;
	endtask

	// Drop valid and wait until every outstanding response has come back
	task automatic drain();
		req_valid <= 1'b0;
		while (table_sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_transfer(bit is_write, logic [PDATA_W-1:0] data,
			output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= TSIZE_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Write the slot count register, then read it back
	task automatic program_tsize(logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] rd;
		apb_transfer(1'b1, data, rd);
		table_sb.set_size(data[TSIZE_W-1:0]);
		@(posedge clk);
		apb_transfer(1'b0, '0, rd);
		if (rd !== PDATA_W'(data[TSIZE_W-1:0])) begin
			table_sb.flag($sformatf("slot count readback expected %0d actual %0d",
				data[TSIZE_W-1:0], rd));
		end
		@(posedge clk);
		sizes_visited++;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			1: begin
				sender_idle_pct = 88;
				receiver_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 88;
			end
			3: begin
				sender_idle_pct = 37;
				receiver_stall_pct = 37;
			end
			default: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
		endcase
	endtask

	initial begin : stimulus
		table_sb = new();
		foreach (name_pool[i]) name_pool[i] = random_name($urandom_range(KEY_CHARS, 1));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_tsize(32'd64);

		// Collision chain at home slot 0: empty key, "a", "A09z", all-ones bytes, "aaaaaaaa"
		send_request(make_req(REQ_PUT, '0, '0));
		send_request(make_req(REQ_PUT, text_key("a"), '1));
		send_request(make_req(REQ_PUT, text_key("Z"), 48'd1));
		send_request(make_req(REQ_PUT, text_key("A09z"), 48'h8000_0000_0001));
		send_request(make_req(REQ_PUT, '1, 48'h5555_AAAA_5555));
		send_request(make_req(REQ_PUT, text_key("aaaaaaaa"), 48'hAAAA_5555_AAAA));
		// noise past the terminator, then the same name again as an update
		send_request(make_req(REQ_PUT, 64'h6162_0078_797A_0000, 48'h1234));
		send_request(make_req(REQ_PUT, text_key("ab"), 48'h5678));
		send_request(make_req(REQ_REMOVE, text_key("ab"), '1));
		send_request(make_req(REQ_REMOVE, text_key("ab"), '0));
		send_request(make_req(REQ_PUT, text_key("ABCDEFGH"), 48'h0F0F_0F0F_0F0F));
		// tombstone in the chain: match past it, then reuse it
		send_request(make_req(REQ_REMOVE, '1, '0));
		send_request(make_req(REQ_PUT, text_key("aaaaaaaa"), 48'h7));
		send_request(make_req(REQ_PUT, text_key("aa"), 48'h9));
		send_request(make_req(REQ_REMOVE, text_key("qq"), '0));

		// Two slots, both taken: full put and full-scan miss on remove
		drain();
		program_tsize(32'd2);
		send_request(make_req(REQ_PUT, text_key("b"), 48'h11));
		send_request(make_req(REQ_REMOVE, text_key("b"), '0));
		send_request(make_req(REQ_REMOVE, text_key("a"), '0));
		send_request(make_req(REQ_PUT, text_key("a"), 48'h22));

		// Size zero acts as one slot
		drain();
		program_tsize(32'd0);
		send_request(make_req(REQ_PUT, text_key("c"), 48'h33));
		send_request(make_req(REQ_PUT, '0, '1));

		// Oversize value clamps to the full table
		drain();
		program_tsize(32'd127);
		send_request(make_req(REQ_REMOVE, text_key("a"), '0));

		// Random phases over table sizes and idling mixes
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain();
			program_tsize(PHASE_SIZES[p]);
			set_idling(p % 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 0 && n == 5) hold_request = HOLD_OFF_CYCLES;
				if (p == 2 && n == 20) drain();
				send_request(random_request());
			end
		end

		req_valid <= 1'b0;
		while (table_sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d requests over %0d slot counts, four idling mixes, %0d-cycle hold-off.",
			requests_sent, sizes_visited, HOLD_OFF_CYCLES);
		$display("%0d inserted, %0d updated, %0d removed, %0d full, %0d not found, %0d mismatches.",
			table_sb.status_seen[ST_INSERTED], table_sb.status_seen[ST_UPDATED],
			table_sb.status_seen[ST_REMOVED], table_sb.status_seen[ST_FULL],
			table_sb.status_seen[ST_NOTFOUND], table_sb.mismatches);
		if (table_sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/lpht_pkg.sv
rtl/core/linear_probe_hash_table.sv
dv/linear_probe_hash_table_tb.sv
